// ===== rtl/core/kvrbp_pkg.sv =====
// Shared types and constants for the key-value request byte parser.
`default_nettype none

package kvrbp_pkg;

  localparam int unsigned LenW = 24;
  localparam int unsigned MaxLengthDigitsDefault = 7;
  localparam logic [LenW-1:0] MaxStringLengthReset = 24'd4194304;

  // Event codes of a result beat
  localparam logic [2:0] EvKeyLen  = 3'd0;
  localparam logic [2:0] EvKeyByte = 3'd1;
  localparam logic [2:0] EvValLen  = 3'd2;
  localparam logic [2:0] EvValByte = 3'd3;
  localparam logic [2:0] EvGetDone = 3'd4;
  localparam logic [2:0] EvSetDone = 3'd5;
  localparam logic [2:0] EvError   = 3'd6;

  // Protocol characters
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChG       = 8'h47;
  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChE       = 8'h45;
  localparam logic [7:0] ChT       = 8'h54;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } item_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [7:0]      payload_byte;
    logic [LenW-1:0] string_length;
    logic            last_of_string;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvrbp_parse.sv =====
// Parser state and the per-byte next-state and event logic.
`default_nettype none

module kvrbp_parse #(
  parameter int unsigned MaxDigits = kvrbp_pkg::MaxLengthDigitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire kvrbp_pkg::item_t              item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [kvrbp_pkg::LenW-1:0]    cfg_data_i,
  output logic                               res_valid_o,
  output kvrbp_pkg::result_t                 res_o
);
  import kvrbp_pkg::*;

  localparam int unsigned DigitW = $clog2(MaxDigits + 1);

  localparam logic [2:0] PhOp0    = 3'd0;
  localparam logic [2:0] PhOp1    = 3'd1;
  localparam logic [2:0] PhOp2    = 3'd2;
  localparam logic [2:0] PhOpen   = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;
  localparam logic [2:0] PhPay    = 3'd5;
  localparam logic [2:0] PhNl     = 3'd6;

  logic [2:0]        phase_q, phase_d, phase_e;
  logic              set_q, set_d, set_e;
  logic              val_q, val_d, val_e;
  logic [DigitW-1:0] dc_q, dc_d, dc_e;
  logic [LenW-1:0]   acc_q, acc_d, acc_e;
  logic [LenW-1:0]   rem_q, rem_d, rem_e;
  logic              err_q, err_d, err_e;
  logic [LenW-1:0]   max_len_q;

  logic [7:0]        b;
  logic              is_digit;
  logic [LenW-1:0]   acc_next;
  logic              last;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= ChZero) && (b <= ChNine);
  assign acc_next = {acc_e[LenW-4:0], 3'b000} + {acc_e[LenW-2:0], 1'b0}
                    + {{(LenW-4){1'b0}}, b[3:0]};
  assign last     = (rem_e <= {{(LenW-1){1'b0}}, 1'b1});

  always_comb begin
    // A new connection restarts the parser before this byte is looked at
    if (item_i.new_connection) begin
      phase_e = PhOp0;
      set_e   = 1'b0;
      val_e   = 1'b0;
      dc_e    = '0;
      acc_e   = '0;
      rem_e   = '0;
      err_e   = 1'b0;
    end else begin
      phase_e = phase_q;
      set_e   = set_q;
      val_e   = val_q;
      dc_e    = dc_q;
      acc_e   = acc_q;
      rem_e   = rem_q;
      err_e   = err_q;
    end

    phase_d     = phase_e;
    set_d       = set_e;
    val_d       = val_e;
    dc_d        = dc_e;
    acc_d       = acc_e;
    rem_d       = rem_e;
    err_d       = err_e;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!err_e) begin
      case (phase_e)
        PhOp0: begin
          if (b == ChG || b == ChS) begin
            set_d   = (b == ChS);
            phase_d = PhOp1;
          end else begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end
        end
        PhOp1: begin
          if (b == ChE) begin
            phase_d = PhOp2;
          end else begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end
        end
        PhOp2: begin
          if (b == ChT) begin
            val_d   = 1'b0;
            phase_d = PhOpen;
          end else begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end
        end
        PhOpen: begin
          if (b == ChDollar) begin
            dc_d    = '0;
            acc_d   = '0;
            phase_d = PhDigits;
          end else begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end
        end
        PhDigits: begin
          if (b == ChDollar) begin
            if (dc_e == '0 || acc_e == '0 || acc_e > max_len_q) begin
              err_d           = 1'b1;
              res_valid_o     = 1'b1;
              res_o.event_res = EvError;
            end else begin
              rem_d               = acc_e;
              phase_d             = PhPay;
              res_valid_o         = 1'b1;
              res_o.event_res     = val_e ? EvValLen : EvKeyLen;
              res_o.string_length = acc_e;
            end
          end else if (!is_digit || dc_e >= DigitW'(MaxDigits)) begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end else begin
            acc_d = acc_next;
            dc_d  = dc_e + {{(DigitW-1){1'b0}}, 1'b1};
          end
        end
        PhPay: begin
          rem_d = last ? '0 : rem_e - {{(LenW-1){1'b0}}, 1'b1};
          if (last) begin
            if (set_e && !val_e) begin
              val_d   = 1'b1;
              phase_d = PhOpen;
            end else begin
              phase_d = PhNl;
            end
          end
          res_valid_o          = 1'b1;
          res_o.event_res      = val_e ? EvValByte : EvKeyByte;
          res_o.payload_byte   = b;
          res_o.last_of_string = last;
        end
        PhNl: begin
          if (b == ChNewline) begin
            phase_d         = PhOp0;
            set_d           = 1'b0;
            val_d           = 1'b0;
            dc_d            = '0;
            acc_d           = '0;
            rem_d           = '0;
            res_valid_o     = 1'b1;
            res_o.event_res = set_e ? EvSetDone : EvGetDone;
          end else begin
            err_d           = 1'b1;
            res_valid_o     = 1'b1;
            res_o.event_res = EvError;
          end
        end
        default: begin
          err_d           = 1'b1;
          res_valid_o     = 1'b1;
          res_o.event_res = EvError;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOp0;
      set_q   <= 1'b0;
      val_q   <= 1'b0;
      dc_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      set_q   <= set_d;
      val_q   <= val_d;
      dc_q    <= dc_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxStringLengthReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kv_request_byte_parser_core.sv =====
// A byte accepted into the input register is parsed from there, and its result beat is captured in the result register.
// Throughput: one byte per cycle; in_ready_o falls only while a held byte waits on a full result
// register that the consumer does not take.
// Bytes producing no result still pass through the input register.
// Reset: asynchronous, active low; clears parser state and both valid flags, and sets the
// maximum string length register to 4194304.
`default_nettype none

module kv_request_byte_parser_core #(
  parameter int unsigned MaxLengthDigits = kvrbp_pkg::MaxLengthDigitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire kvrbp_pkg::item_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output kvrbp_pkg::result_t              out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [kvrbp_pkg::LenW-1:0] cfg_data_i
);
  import kvrbp_pkg::*;

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;
  logic    fire;
  logic    res_valid;
  result_t res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  kvrbp_parse #(
    .MaxDigits (MaxLengthDigits)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: hold the beat until the parser consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/kvrbp_chk.sv =====
// Port-level checks for the parser core, bound to the top level.
`default_nettype none

module kvrbp_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire kvrbp_pkg::result_t         out_data_o
);
  import kvrbp_pkg::*;

  logic byte_ev;
  logic len_ev;

  assign byte_ev = (out_data_o.event_res == EvKeyByte) || (out_data_o.event_res == EvValByte);
  assign len_ev  = (out_data_o.event_res == EvKeyLen) || (out_data_o.event_res == EvValLen);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.event_res <= EvError)
    else $error("event code out of range");

  a_len_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (len_ev ? (out_data_o.string_length != '0)
                            : (out_data_o.string_length == '0)))
    else $error("string length inconsistent with event");

  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_ev |-> !out_data_o.last_of_string && out_data_o.payload_byte == '0)
    else $error("payload fields set on a non-byte event");

endmodule

bind kv_request_byte_parser_core kvrbp_chk u_kvrbp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/tb_kv_request_byte_parser_core.sv =====
// Self-checking testbench for the key-value request byte parser core.
module tb_kv_request_byte_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kvrbp_pkg::*;

  localparam int unsigned RandomBytes   = 1950;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles  = 6;

  typedef enum logic [2:0] {
    PhOpcode0, PhOpcode1, PhOpcode2, PhOpen, PhDigits, PhPayload, PhNewline
  } parse_phase_e;

  typedef enum int {
    FlawNone, FlawOpcode, FlawOpLetter, FlawNoDollar, FlawBadDigit, FlawEmptyLen,
    FlawTooManyDigits, FlawRange, FlawNoNewline, FlawNoise, FlawCutShort
  } flaw_e;

  // Tracks parser state and holds the result beats still owed by the block.
  class request_scoreboard;
    logic [LenW-1:0] max_len;
    parse_phase_e    parse_phase;
    bit              is_set;
    bit              on_value;
    bit              err_latched;
    logic [2:0]      digit_cnt;
    logic [LenW-1:0] len_acc;
    logic [LenW-1:0] remaining;
    result_t         expected_q[$];
    int unsigned     parsed_bytes;
    int unsigned     mismatches;

    function new();
      max_len      = MaxStringLengthReset;
      parsed_bytes = 0;
      mismatches   = 0;
      restart();
    endfunction

    function void restart();
      parse_phase = PhOpcode0;
      is_set      = 1'b0;
      on_value    = 1'b0;
      err_latched = 1'b0;
      digit_cnt   = '0;
      len_acc     = '0;
      remaining   = '0;
    endfunction

    function void owe_beat(logic [2:0] ev, logic [7:0] pb, logic [LenW-1:0] len, logic last);
      result_t r;
      r.event_res      = ev;
      r.payload_byte   = pb;
      r.string_length  = len;
      r.last_of_string = last;
      expected_q.push_back(r);
    endfunction

    function void raise_error();
      err_latched = 1'b1;
      owe_beat(EvError, '0, '0, 1'b0);
    endfunction

    function void note_byte(item_t it);
      logic [7:0] b;
      bit         val;
      logic       last;
      logic [2:0] done_ev;
      b   = it.data_byte;
      val = on_value;
      if (it.new_connection) restart();
      // drop everything until a new connection once an error is latched
      if (err_latched) return;
      parsed_bytes++;
      case (parse_phase)
        PhOpcode0: begin
          if (b == ChG || b == ChS) begin
            is_set      = (b == ChS);
            parse_phase = PhOpcode1;
          end else raise_error();
        end
        PhOpcode1: begin
          if (b == ChE) parse_phase = PhOpcode2;
          else raise_error();
        end
        PhOpcode2: begin
          if (b == ChT) begin
            on_value    = 1'b0;
            parse_phase = PhOpen;
          end else raise_error();
        end
        PhOpen: begin
          if (b == ChDollar) begin
            digit_cnt   = '0;
            len_acc     = '0;
            parse_phase = PhDigits;
          end else raise_error();
        end
        PhDigits: begin
          if (b == ChDollar) begin
            if (digit_cnt == 0 || len_acc == 0 || len_acc > max_len) raise_error();
            else begin
              remaining   = len_acc;
              parse_phase = PhPayload;
              owe_beat(val ? EvValLen : EvKeyLen, '0, len_acc, 1'b0);
            end
          end else if (b < ChZero || b > ChNine || digit_cnt >= MaxLengthDigitsDefault) begin
            raise_error();
          end else begin
            len_acc   = LenW'(len_acc * 10 + (b - ChZero));
            digit_cnt = digit_cnt + 3'd1;
          end
        end
        PhPayload: begin
          last      = (remaining <= 1);
          remaining = last ? '0 : remaining - 1'b1;
          if (last) begin
            if (is_set && !on_value) begin
              on_value    = 1'b1;
              parse_phase = PhOpen;
            end else parse_phase = PhNewline;
          end
          owe_beat(val ? EvValByte : EvKeyByte, b, '0, last);
        end
        PhNewline: begin
          if (b == ChNewline) begin
            done_ev = is_set ? EvSetDone : EvGetDone;
            restart();
            owe_beat(done_ev, '0, '0, 1'b0);
          end else raise_error();
        end
        default: raise_error();
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat, event_res %0d", got.event_res);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("string_length", want.string_length, got.string_length);
      compare_field("last_of_string", want.last_of_string, got.last_of_string);
    endfunction
  endclass

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  item_t           in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  result_t         out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [LenW-1:0] cfg_data_i  = '0;

  logic              steady      = 1'b0;
  logic              holding     = 1'b0;
  int unsigned       cycle_count = 0;
  event              hold_off_ev;
  item_t             req_bytes[$];
  request_scoreboard sb = new();

  kv_request_byte_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_kv_request_byte_parser_core failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= !holding && (steady || $urandom_range(0, 99) >= 33);
  end

  // Hold the result side off so the block backs up into its input.
  initial forever begin
    @(hold_off_ev);
    holding <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  task automatic send_item(item_t it);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(it);
  endtask

  task automatic send_request();
    while (req_bytes.size() != 0) send_item(req_bytes.pop_front());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(logic [LenW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.max_len = value;
  endtask

  function automatic void push_byte(logic [7:0] value, bit fresh = 1'b0);
    item_t it;
    it.data_byte      = value;
    it.new_connection = fresh;
    req_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] value;
    do value = 8'($urandom_range(0, 255)); while (value == a || value == b);
    return value;
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'(ChZero + $urandom_range(0, 9));
  endfunction

  // Decimal length, optionally padded with leading zeros up to the digit limit.
  function automatic void push_digits(int unsigned value, bit pad);
    logic [7:0]  digits[$];
    int unsigned width;
    do begin
      digits.push_front(8'(ChZero + value % 10));
      value /= 10;
    end while (value != 0);
    width = pad ? $urandom_range(digits.size(), MaxLengthDigitsDefault) : digits.size();
    while (digits.size() < width) digits.push_front(ChZero);
    foreach (digits[i]) push_byte(digits[i]);
  endfunction

  // Returns 1 when the string was broken off by a flaw.
  function automatic bit push_string(bit flawed, flaw_e flaw);
    logic [LenW-1:0] lim;
    logic [7:0]      odd;
    int unsigned     cap;
    int unsigned     len;
    lim = sb.max_len;
    if (flawed && flaw == FlawNoDollar) begin
      push_byte(byte_except(ChDollar, ChDollar));
      return 1'b1;
    end
    push_byte(ChDollar);
    if (flawed) begin
      case (flaw)
        FlawEmptyLen: begin
          push_byte(ChDollar);
          return 1'b1;
        end
        FlawTooManyDigits: begin
          repeat (MaxLengthDigitsDefault + 1) push_byte(random_digit());
          return 1'b1;
        end
        FlawBadDigit: begin
          repeat ($urandom_range(0, MaxLengthDigitsDefault)) push_byte(random_digit());
          do odd = 8'($urandom_range(0, 255));
          while ((odd >= ChZero && odd <= ChNine) || odd == ChDollar);
          push_byte(odd);
          return 1'b1;
        end
        FlawRange: begin
          if (lim < 24'd9999999 && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 1) == 1) push_digits(lim + 1, 1'b1);
            else push_digits($urandom_range(lim + 1, 9999999), 1'b1);
          end else begin
            repeat ($urandom_range(1, MaxLengthDigitsDefault)) push_byte(ChZero);
          end
          push_byte(ChDollar);
          return 1'b1;
        end
        default: ;
      endcase
    end
    // keep payloads short; a register of zero still gets a length to reject
    cap = (lim == 0) ? 4 : (lim < 8 ? lim : 8);
    if (lim > 8 && $urandom_range(0, 9) == 0) cap = (lim < 40) ? lim : 40;
    len = $urandom_range(1, cap);
    push_digits(len, $urandom_range(0, 9) < 4);
    push_byte(ChDollar);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    return 1'b0;
  endfunction

  function automatic void build_request(flaw_e flaw, bit fresh);
    bit          set_req;
    int unsigned strings;
    int unsigned flawed_idx;
    int unsigned keep;
    if (flaw == FlawNoise) begin
      repeat ($urandom_range(1, 6))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      return;
    end
    set_req    = $urandom_range(0, 1);
    strings    = set_req ? 2 : 1;
    flawed_idx = $urandom_range(0, strings - 1);
    if (flaw == FlawOpcode) begin
      push_byte(byte_except(ChG, ChS), fresh);
      return;
    end
    push_byte(set_req ? ChS : ChG, fresh);
    if (flaw == FlawOpLetter && $urandom_range(0, 1) == 0) begin
      push_byte(byte_except(ChE, ChE));
      return;
    end
    push_byte(ChE);
    if (flaw == FlawOpLetter) begin
      push_byte(byte_except(ChT, ChT));
      return;
    end
    push_byte(ChT);
    for (int i = 0; i < strings; i++)
      if (push_string(i == flawed_idx, flaw)) return;
    push_byte(flaw == FlawNoNewline ? byte_except(ChNewline, ChNewline) : ChNewline);
    // abandon a well-formed request part way; the next one opens a new connection
    if (flaw == FlawCutShort) begin
      keep = $urandom_range(1, req_bytes.size() - 1);
      while (req_bytes.size() > keep) void'(req_bytes.pop_back());
    end
  endfunction

  function automatic void build_directed();
    push_byte(ChG, 1'b1);
    push_byte(ChE);
    push_byte(ChT);
    push_byte(ChDollar);
    push_byte(8'(ChZero + 1));
    push_byte(ChDollar);
    push_byte(8'hFF);
    push_byte(ChNewline);
    push_byte(ChS);
    push_byte(ChE);
    push_byte(ChT);
    push_byte(ChDollar);
    push_byte(8'(ChZero + 1));
    push_byte(ChDollar);
    push_byte(8'h00);
    push_byte(ChDollar);
    push_byte(ChZero);
    push_byte(8'(ChZero + 2));
    push_byte(ChDollar);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(ChNewline);
    // bad opcode on a fresh connection, then a byte that must be dropped
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00);
  endfunction

  initial begin : stimulus
    logic [LenW-1:0] phase_max [PhaseCount];
    int unsigned     target;
    flaw_e           flaw;
    bit              fresh;
    phase_max = '{MaxStringLengthReset, 24'd9999999, 24'd1, 24'hFFFFFF,
                  24'd0, 24'd7, 24'd20, 24'd3};
    phase_max[6] = LenW'($urandom_range(9, 60));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_directed();
    send_request();
    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) begin
        drain();
        write_max_len(phase_max[p]);
      end
      steady <= (p == 1);
      if (p == 2) -> hold_off_ev;
      target = sb.parsed_bytes + RandomBytes / PhaseCount;
      while (sb.parsed_bytes < target) begin
        fresh = sb.err_latched || sb.parse_phase != PhOpcode0 || $urandom_range(0, 4) == 0;
        if ($urandom_range(0, 99) < 75) flaw = FlawNone;
        else flaw = flaw_e'($urandom_range(FlawOpcode, FlawCutShort));
        build_request(flaw, fresh);
        send_request();
      end
    end
    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_kv_request_byte_parser_core passed");
    end else begin
      $display("tb_kv_request_byte_parser_core failed");
    end
    $finish;
  end

endmodule

// ===== kv_request_byte_parser_core.f =====
rtl/core/kvrbp_pkg.sv
rtl/core/kvrbp_parse.sv
rtl/core/kv_request_byte_parser_core.sv
rtl/core/kvrbp_chk.sv
dv/tb_kv_request_byte_parser_core.sv
